// ----- rtl/core/srect_pkg.sv -----
// Shared types, constants and helpers for the segment/rectangle hit test.
// Used by every stage module and the top level; no dependencies.
package srect_pkg;

    localparam int COORD_BITS    = 16;
    localparam int NUM_IN_FIELDS = 8;
    localparam int IN_TDATA_W    = ((NUM_IN_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = 8;

    localparam int NUM_EDGES   = 4;
    // per edge: two orientations of the segment endpoints about the edge line,
    // then one orientation per rectangle corner about the segment line
    localparam int CORNER_BASE = 2 * NUM_EDGES;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_ORIENT  = CORNER_BASE + NUM_CORNERS;

    // corner code: bit 1 picks max x, bit 0 picks max y
    localparam logic [1:0] CRN_LB = 2'b00;
    localparam logic [1:0] CRN_LT = 2'b01;
    localparam logic [1:0] CRN_RB = 2'b10;
    localparam logic [1:0] CRN_RT = 2'b11;

    // left, bottom, right, top edges
    localparam logic [1:0] EDGE_Q1 [NUM_EDGES] = '{CRN_LT, CRN_LB, CRN_RB, CRN_LT};
    localparam logic [1:0] EDGE_Q2 [NUM_EDGES] = '{CRN_LB, CRN_RB, CRN_RT, CRN_RT};

    typedef logic signed [COORD_BITS-1:0]     coord_t;
    typedef logic signed [COORD_BITS:0]       diff_t;
    typedef logic signed [2*COORD_BITS+1:0]   prod_t;

    typedef struct packed {
        diff_t dax;
        diff_t day;
        diff_t dbx;
        diff_t dby;
    } diff4_t;

    typedef struct packed {
        prod_t p;
        prod_t q;
    } prod2_t;

    typedef struct packed {
        logic pos;
        logic neg;
    } sgn_t;

    typedef struct packed {
        diff4_t [NUM_ORIENT-1:0] d;
        logic                    in_s;
        logic                    in_e;
    } prep_t;

    typedef struct packed {
        prod2_t [NUM_ORIENT-1:0] pr;
        logic                    in_s;
        logic                    in_e;
    } mult_t;

    typedef struct packed {
        sgn_t [NUM_ORIENT-1:0] s;
        logic                  in_s;
        logic                  in_e;
    } cmp_t;

    // operands of (a - t) x (b - t)
    function automatic diff4_t orient_diff(input coord_t ax, input coord_t ay,
                                           input coord_t bx, input coord_t by,
                                           input coord_t tx, input coord_t ty);
        diff4_t r;
        r.dax = diff_t'(ax) - diff_t'(tx);
        r.day = diff_t'(ay) - diff_t'(ty);
        r.dbx = diff_t'(bx) - diff_t'(tx);
        r.dby = diff_t'(by) - diff_t'(ty);
        return r;
    endfunction

    function automatic logic same_strict(input sgn_t a, input sgn_t b);
        return (a.pos & b.pos) | (a.neg & b.neg);
    endfunction

endpackage

// ----- rtl/core/segment_rect_intersect.sv -----
// Segment versus axis-aligned rectangle hit test, top level.
// Depends on srect_pkg, srect_prep, srect_mult and srect_cmp.
//
// Usage:
//   Input stream (s_axis_*): one word per query, eight 16-bit signed
//   coordinates: segment start x/y, segment end x/y, rectangle min x/y,
//   rectangle max x/y, lowest bits first. Output stream (m_axis_*): one word
//   per query, bit 0 = hit (segment touches or crosses the rectangle, edges
//   inclusive; a segment collinear with an edge line also reports a hit).
//   Throughput: one query per cycle, sustained, with no gaps, while m_axis_tready is high.
//   The stages are operand subtract, product multiply, product compare,
//   and the hit combine into the output register, in that order.
//   Each of the four stages holds its own valid bit and loads whenever it is
//   empty or its word moves on, so bubbles collapse and s_axis_tready stays
//   high while the output register is empty or m_axis_tready is high.
//   When the receiver stalls, words pile up in the stages; once all four are
//   full s_axis_tready drops, and nothing is lost or repeated.
//   Reset (rst_n low, asynchronous) empties the pipeline; there is no other
//   state.
module segment_rect_intersect (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    // box_min_x, box_min_y, box_max_x, box_max_y
    input  logic [srect_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // hit, zero padding above
    output logic [srect_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import srect_pkg::*;

    logic  s1_valid, s1_ready;
    prep_t s1_data;
    logic  s2_valid, s2_ready;
    mult_t s2_data;
    logic  s3_valid, s3_ready;
    cmp_t  s3_data;

    logic  out_valid_reg;
    logic  hit_reg;
    logic  hit_next;
    logic  [NUM_EDGES-1:0] edge_hit;

    srect_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    srect_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    srect_cmp u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    // an edge is crossed unless one pair of signs is strictly the same
    always_comb
    begin
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            edge_hit[k] = !same_strict(s3_data.s[2*k], s3_data.s[2*k+1])
                       && !same_strict(s3_data.s[CORNER_BASE + int'(EDGE_Q1[k])],
                                       s3_data.s[CORNER_BASE + int'(EDGE_Q2[k])]);
        end
        hit_next = s3_data.in_s || s3_data.in_e || (|edge_hit);
    end

    assign s3_ready      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(hit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s3_ready)
            out_valid_reg <= s3_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid && s3_ready)
            hit_reg <= hit_next;
    end

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while sink is ready");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid && m_axis_tready) |=> m_axis_tvalid)
        else $error("finished word did not reach output register");
`endif

endmodule

// ----- rtl/core/srect_prep.sv -----
// Stage 1: unpacks the input word, forms all cross-product operands and the
// endpoint containment flags. Depends on srect_pkg.
module srect_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [srect_pkg::IN_TDATA_W-1:0] in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output srect_pkg::prep_t              out_data
);
    import srect_pkg::*;

    coord_t sx, sy, ex, ey, x0, y0, x1, y1;
    coord_t cx [NUM_CORNERS];
    coord_t cy [NUM_CORNERS];
    logic   valid_reg;
    prep_t  data_reg;
    prep_t  data_next;
    logic   load;

    assign sx = coord_t'(in_data[0*COORD_BITS +: COORD_BITS]);
    assign sy = coord_t'(in_data[1*COORD_BITS +: COORD_BITS]);
    assign ex = coord_t'(in_data[2*COORD_BITS +: COORD_BITS]);
    assign ey = coord_t'(in_data[3*COORD_BITS +: COORD_BITS]);
    assign x0 = coord_t'(in_data[4*COORD_BITS +: COORD_BITS]);
    assign y0 = coord_t'(in_data[5*COORD_BITS +: COORD_BITS]);
    assign x1 = coord_t'(in_data[6*COORD_BITS +: COORD_BITS]);
    assign y1 = coord_t'(in_data[7*COORD_BITS +: COORD_BITS]);

    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            cx[c] = (c >= 2) ? x1 : x0;
            cy[c] = (c % 2 == 1) ? y1 : y0;
        end
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            data_next.d[2*k]   = orient_diff(cx[EDGE_Q1[k]], cy[EDGE_Q1[k]],
                                             cx[EDGE_Q2[k]], cy[EDGE_Q2[k]], sx, sy);
            data_next.d[2*k+1] = orient_diff(cx[EDGE_Q1[k]], cy[EDGE_Q1[k]],
                                             cx[EDGE_Q2[k]], cy[EDGE_Q2[k]], ex, ey);
        end
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            data_next.d[CORNER_BASE+c] = orient_diff(sx, sy, ex, ey, cx[c], cy[c]);
        end
        data_next.in_s = (sx >= x0) && (sx <= x1) && (sy >= y0) && (sy <= y1);
        data_next.in_e = (ex >= x0) && (ex <= x1) && (ey >= y0) && (ey <= y1);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

// ----- rtl/core/srect_mult.sv -----
// Stage 2: the two products of every cross product, registered.
// Depends on srect_pkg.
module srect_mult (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  srect_pkg::prep_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output srect_pkg::mult_t out_data
);
    import srect_pkg::*;

    logic  valid_reg;
    mult_t data_reg;
    mult_t data_next;
    logic  load;

    always_comb
    begin
        for (int i = 0; i < NUM_ORIENT; i++)
        begin
            data_next.pr[i].p = prod_t'(in_data.d[i].dax) * prod_t'(in_data.d[i].dby);
            data_next.pr[i].q = prod_t'(in_data.d[i].day) * prod_t'(in_data.d[i].dbx);
        end
        data_next.in_s = in_data.in_s;
        data_next.in_e = in_data.in_e;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule

// ----- rtl/core/srect_cmp.sv -----
// Stage 3: reduces each product pair to an orientation sign (pos/neg/zero).
// Depends on srect_pkg.
module srect_cmp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  srect_pkg::mult_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output srect_pkg::cmp_t  out_data
);
    import srect_pkg::*;

    logic valid_reg;
    cmp_t data_reg;
    cmp_t data_next;
    logic load;

    always_comb
    begin
        for (int i = 0; i < NUM_ORIENT; i++)
        begin
            data_next.s[i].pos = in_data.pr[i].p > in_data.pr[i].q;
            data_next.s[i].neg = in_data.pr[i].p < in_data.pr[i].q;
        end
        data_next.in_s = in_data.in_s;
        data_next.in_e = in_data.in_e;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

endmodule
